// File: rtl/core/sda_pkg.sv
package sda_pkg;

   localparam int IDX_W       = 12;
   localparam int VAL_W       = 32;
   localparam int TERM_W      = 48;
   localparam int SUM_W       = 64;
   localparam int REQ_DATA_W  = 56;
   localparam int RSP_DATA_W  = 48;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [VAL_W-1:0] REST_DENSITY_RESET = 32'd65536000;
   localparam logic [VAL_W-1:0] SELF_KERNEL_RESET  = 32'd65536;

   typedef enum logic [2:0] {
      KIND_LOAD_FLUID  = 3'd0,
      KIND_LOAD_SOLID  = 3'd1,
      KIND_BEGIN_FLUID = 3'd2,
      KIND_BEGIN_SOLID = 3'd3,
      KIND_NEIGHBOR    = 3'd4
   } kind_type;

   typedef enum logic {
      CSR_REST_DENSITY = 1'b0,
      CSR_SELF_KERNEL  = 1'b1
   } csr_index_type;

   // One decoded word as it waits in the queue. index is the particle for
   // loads and begins, and the neighbor for neighbor terms.
   typedef struct packed {
      kind_type         kind;
      logic [IDX_W-1:0] index;
      logic             idx_ok;
      logic [VAL_W-1:0] value;
      logic             last;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_ACC,
      ST_DREAD,
      ST_CLOSE
   } state_type;

endpackage

// File: rtl/core/sda_front.sv
module sda_front
   import sda_pkg::*;
#(
   parameter int MAX_PARTICLES = 4096
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2:0]            req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tlast,
   input  logic                  queue_full,
   input  logic                  clearing,
   output logic                  push,
   output cmd_type               cmd
);

   kind_type         kind;
   logic [IDX_W-1:0] particle;
   logic [IDX_W-1:0] neighbor;
   logic [IDX_W-1:0] index;
   logic             idx_ok;
   logic             useful;

   assign kind     = kind_type'(req_tuser);
   assign particle = req_tdata[IDX_W-1:0];
   assign neighbor = req_tdata[2*IDX_W-1:IDX_W];
   assign index    = (kind == KIND_NEIGHBOR) ? neighbor : particle;
   assign idx_ok   = {{(32-IDX_W){1'b0}}, index} < 32'(MAX_PARTICLES);

   // Unused kinds and loads past the end of the stores change nothing, so
   // they are dropped here and never reach the queue.
   always_comb begin
      case (kind)
         KIND_LOAD_FLUID, KIND_LOAD_SOLID: useful = idx_ok;
         KIND_BEGIN_FLUID, KIND_BEGIN_SOLID, KIND_NEIGHBOR: useful = 1'b1;
         default: useful = 1'b0;
      endcase
   end

   assign req_tready = !queue_full && !clearing;
   assign push       = req_tvalid && req_tready && useful;

   assign cmd.kind   = kind;
   assign cmd.index  = index;
   assign cmd.idx_ok = idx_ok;
   assign cmd.value  = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
   assign cmd.last   = req_tlast;

endmodule

// File: rtl/core/sda_queue.sv
module sda_queue
   import sda_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type cmd_in,
   input  logic    pop,
   output cmd_type cmd_out,
   output logic    empty,
   output logic    full
);

   cmd_type           entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign cmd_out = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

// File: rtl/core/sda_back.sv
module sda_back
   import sda_pkg::*;
#(
   parameter int MAX_PARTICLES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               head,
   input  logic                  queue_empty,
   output logic                  pop,
   output logic                  clearing,
   input  logic [VAL_W-1:0]      rest_density,
   input  logic [VAL_W-1:0]      self_kernel_weight,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int DEPTH = (MAX_PARTICLES < (1 << IDX_W)) ? MAX_PARTICLES : (1 << IDX_W);
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic [VAL_W-1:0] fluid_mem [DEPTH];
   logic [VAL_W-1:0] solid_mem [DEPTH];
   logic [VAL_W-1:0] dens_mem  [DEPTH];
   logic [VAL_W-1:0] fluid_rd_ff;
   logic [VAL_W-1:0] solid_rd_ff;
   logic [VAL_W-1:0] dens_rd_ff;

   logic [AW-1:0]     clear_addr_ff;
   logic [VAL_W-1:0]  kernel_ff;
   logic              begin_ff;
   logic              vol_ok_ff;
   logic              last_ff;
   logic [VAL_W-1:0]  mass_ff;
   logic [TERM_W-1:0] term_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [IDX_W-1:0]  cur_particle_ff;
   logic              cur_ok_ff;
   logic              solid_pass_ff;

   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_particle_ff;
   logic [VAL_W-1:0]  rsp_density_ff;
   logic              rsp_sat_ff;

   logic fluid_we, solid_we, vol_re, dens_re, dens_we, out_load, out_free;
   logic clear_done;

   logic [AW-1:0]      vol_addr;
   logic [AW-1:0]      dens_addr;
   logic [VAL_W-1:0]   dens_wdata;
   logic [VAL_W-1:0]   volume;
   logic [2*VAL_W-1:0] mass_prod;
   logic [2*VAL_W-1:0] term_prod;
   logic [SUM_W:0]     acc_sum;
   logic [SUM_W-1:0]   acc_sat;
   logic [VAL_W-1:0]   old_density;
   logic [SUM_W:0]     close_sum;
   logic [SUM_W-1:0]   close_total;
   logic               close_sat;
   logic [VAL_W-1:0]   close_density;

   assign clear_done = (clear_addr_ff == AW'(DEPTH - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clearing   = (state_ff == ST_CLEAR);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               case (head.kind)
                  KIND_BEGIN_FLUID, KIND_NEIGHBOR: state_in = ST_MUL1;
                  KIND_BEGIN_SOLID: state_in = head.last ? ST_DREAD : ST_IDLE;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_ACC;
         ST_ACC: state_in = last_ff ? ST_DREAD : ST_IDLE;
         ST_DREAD: state_in = ST_CLOSE;
         ST_CLOSE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs per state.
   always_comb begin
      pop      = 1'b0;
      fluid_we = 1'b0;
      solid_we = 1'b0;
      vol_re   = 1'b0;
      dens_re  = 1'b0;
      dens_we  = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_CLEAR: dens_we = 1'b1;
         ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               case (head.kind)
                  KIND_LOAD_FLUID: fluid_we = head.idx_ok;
                  KIND_LOAD_SOLID: solid_we = head.idx_ok;
                  KIND_BEGIN_FLUID, KIND_NEIGHBOR: vol_re = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_DREAD: dens_re = 1'b1;
         ST_CLOSE: begin
            out_load = out_free;
            dens_we  = out_free && cur_ok_ff;
         end
         default: ;
      endcase
   end

   assign vol_addr   = head.index[AW-1:0];
   assign dens_addr  = clearing ? clear_addr_ff : cur_particle_ff[AW-1:0];
   assign dens_wdata = clearing ? '0 : close_density;

   always_ff @(posedge clock) begin
      if (fluid_we) fluid_mem[vol_addr] <= head.value;
      if (vol_re) fluid_rd_ff <= fluid_mem[vol_addr];
   end

   always_ff @(posedge clock) begin
      if (solid_we) solid_mem[vol_addr] <= head.value;
      if (vol_re) solid_rd_ff <= solid_mem[vol_addr];
   end

   always_ff @(posedge clock) begin
      if (dens_we) dens_mem[dens_addr] <= dens_wdata;
      if (dens_re) dens_rd_ff <= dens_mem[dens_addr];
   end

   // Arithmetic: mass is Q16.16 and always below 2^32; a term stays below 2^48.
   assign volume    = vol_ok_ff ? (solid_pass_ff ? solid_rd_ff : fluid_rd_ff) : '0;
   assign mass_prod = {{VAL_W{1'b0}}, rest_density} * {{VAL_W{1'b0}}, volume};
   assign term_prod = {{VAL_W{1'b0}}, kernel_ff} * {{VAL_W{1'b0}}, mass_ff};
   assign acc_sum   = {1'b0, sum_ff} + {{(SUM_W-TERM_W+1){1'b0}}, term_ff};
   assign acc_sat   = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];

   assign old_density   = (solid_pass_ff && cur_ok_ff) ? dens_rd_ff : '0;
   assign close_sum     = {1'b0, sum_ff} + {{(SUM_W-VAL_W+1){1'b0}}, old_density};
   assign close_total   = close_sum[SUM_W] ? '1 : close_sum[SUM_W-1:0];
   assign close_sat     = |close_total[SUM_W-1:VAL_W];
   assign close_density = close_sat ? '1 : close_total[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_addr_ff   <= '0;
         sum_ff          <= '0;
         cur_particle_ff <= '0;
         cur_ok_ff       <= 1'b1;
         solid_pass_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) clear_addr_ff <= clear_addr_ff + 1'b1;
         if (state_ff == ST_IDLE && pop) begin
            if (head.kind == KIND_BEGIN_FLUID || head.kind == KIND_BEGIN_SOLID) begin
               cur_particle_ff <= head.index;
               cur_ok_ff       <= head.idx_ok;
               solid_pass_ff   <= (head.kind == KIND_BEGIN_SOLID);
            end
            if (head.kind == KIND_BEGIN_SOLID) sum_ff <= '0;
         end
         if (state_ff == ST_ACC) begin
            sum_ff <= begin_ff ? {{(SUM_W-TERM_W){1'b0}}, term_ff} : acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop) begin
         kernel_ff <= (head.kind == KIND_BEGIN_FLUID) ? self_kernel_weight : head.value;
         begin_ff  <= (head.kind == KIND_BEGIN_FLUID);
         vol_ok_ff <= head.idx_ok;
         last_ff   <= head.last;
      end
      if (state_ff == ST_MUL1) mass_ff <= mass_prod[2*VAL_W-1:VAL_W];
      if (state_ff == ST_MUL2) term_ff <= term_prod[TERM_W+15:16];
   end

   // Output register: the next word may be worked on while a result waits.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_particle_ff <= cur_particle_ff;
         rsp_density_ff  <= close_density;
         rsp_sat_ff      <= close_sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-IDX_W-VAL_W){1'b0}}, rsp_density_ff, rsp_particle_ff};
   assign rsp_tuser  = rsp_sat_ff;

endmodule

// File: rtl/core/sph_density_accumulator.sv
// SPH density accumulator.
// Input words arrive on req_*: tuser carries the kind, tlast closes a sum,
// tdata carries particle, neighbor and operand. Loads store a volume, a
// begin opens a particle's sum, neighbor words add kernel-weighted masses,
// and a closing word writes the density store for an in-range particle and
// emits one word on rsp_* (particle and density in tdata, the saturation flag in tuser).
// The front decodes and drops words that change nothing, and a four-entry
// queue sits between it and the execution sequencer.
// Steps per word in the sequencer: a load or a solid begin is handled in idle
// alone, and a fluid begin or a neighbor term runs a volume read, two chained
// multiplies and an accumulate. A closing word adds a density read, then the
// write and emit.
// After reset all min(MAX_PARTICLES, 4096) entries of the density store are
// cleared one entry per cycle; req_tready stays low meanwhile. csr_*
// writes are taken at any time but belong to quiet periods.
// A stalled rsp_tready holds the result in its output register; the next
// word keeps running until it needs to emit, and the queue fills before
// req_tready drops.
module sph_density_accumulator
   import sda_pkg::*;
#(
   parameter int MAX_PARTICLES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // particle[11:0], neighbor[23:12], operand_value[55:24]
   input  logic [2:0]            req_tuser,   // kind[2:0]
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // particle_out[11:0], density[43:12]
   output logic                  rsp_tuser,   // saturated[0]
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [VAL_W-1:0]      csr_wdata
);

   logic [VAL_W-1:0] rest_density_ff;
   logic [VAL_W-1:0] self_kernel_ff;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push, q_pop, q_empty, q_full;
   logic    clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_density_ff <= REST_DENSITY_RESET;
         self_kernel_ff  <= SELF_KERNEL_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_REST_DENSITY: rest_density_ff <= csr_wdata;
            CSR_SELF_KERNEL:  self_kernel_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   sda_front #(
      .MAX_PARTICLES(MAX_PARTICLES)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (q_full),
      .clearing   (clearing),
      .push       (q_push),
      .cmd        (push_cmd)
   );

   sda_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .cmd_in  (push_cmd),
      .pop     (q_pop),
      .cmd_out (head_cmd),
      .empty   (q_empty),
      .full    (q_full)
   );

   sda_back #(
      .MAX_PARTICLES(MAX_PARTICLES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head_cmd),
      .queue_empty        (q_empty),
      .pop                (q_pop),
      .clearing           (clearing),
      .rest_density       (rest_density_ff),
      .self_kernel_weight (self_kernel_ff),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser)
   );

   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset) clearing |-> !req_tready
   ) else $error("input accepted during density clearing pass");

   a_clear_after_reset: assert property (
      @(posedge clock) $past(reset) |-> clearing
   ) else $error("clearing pass did not start after reset");

   a_pop_not_empty: assert property (
      @(posedge clock) disable iff (reset) q_pop |-> !q_empty
   ) else $error("sequencer popped an empty queue");

   a_no_push_when_full: assert property (
      @(posedge clock) disable iff (reset) q_push |-> !q_full
   ) else $error("front pushed into a full queue");

endmodule
